FILE: src/seeded_crc32_report_checker_top_macros.svh
// Assertion macros used by the scrc_frame module of the seeded CRC-32 report checker.
`ifndef SEEDED_CRC32_REPORT_CHECKER_TOP_MACROS_SVH
`define SEEDED_CRC32_REPORT_CHECKER_TOP_MACROS_SVH

// Implication checked on every rising edge, idle while the reset is asserted.
`define SCRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition checked in the cycle after its trigger.
`define SCRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/scrc_pkg.sv
// Package with the types, constants and CRC helper of the seeded CRC-32 report checker.
package scrc_pkg;

	localparam int unsigned REPORT_BYTES_DEF = 78;

	localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
	localparam logic [7:0]  HEADER_BYTE = 8'ha1;
	localparam logic [7:0]  SEED_BYTE   = 8'ha1;

	localparam logic [7:0] REPORT_ID_RESET = 8'd49;

	// Configuration register map.
	localparam int unsigned     APB_ADDR_W         = 3;
	localparam logic [APB_ADDR_W-1:0] REG_REPORT_ID_ADDR = 3'd0;

	// Verdict codes.
	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_LEN_ID   = 2'd1;
	localparam logic [1:0] VERDICT_CRC_FAIL = 2'd2;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] computed_crc;
		logic [31:0] received_crc;
		logic        header_present;
	} result_t;

	// One byte through the reflected CRC-32, eight shift steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	localparam logic [31:0] CRC_SEEDED = crc_byte(CRC_INIT, SEED_BYTE);

endpackage

FILE: src/seeded_crc32_report_checker_top.sv
// Top level of the seeded CRC-32 report checker.
//
// Report bytes enter on the s_ stream, one byte per request, with s_tlast on
// the closing byte. A leading 0xA1 is skipped as a header; the next byte must
// match the identifier register, and the body is checked against a seeded
// reflected CRC-32 carried little-endian in the last four bytes.
// One verdict per report leaves on the m_ stream after the closing byte.
// Each byte is held in an input register, where the eight-step CRC
// update and the verdict compare are done; the verdict then sits in the
// output register, so m_tvalid rises once the closing byte has passed both.
// Throughput is one byte per cycle while no closing byte waits on a held verdict.
// When m_tready is low the held verdict stays put; body bytes keep flowing,
// and only a further closing byte waits until the verdict has been taken.
// Reset clears the report state, empties both registers and restores the
// identifier to 49. The identifier is written over the APB port; the user
// writes it only while no report is in flight; the block does not enforce it.
module seeded_crc32_report_checker_top #(
	parameter int unsigned REPORT_BYTES = scrc_pkg::REPORT_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [71:0]                     m_tdata,   // [1:0] verdict, [33:2] computed_crc,
	                                                   // [65:34] received_crc, [71:66] zero
	output logic                            m_tuser,   // [0] header_present
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scrc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic              out_room;
	logic              res_push;
	logic [7:0]        id_byte;
	scrc_pkg::result_t res;
	scrc_pkg::result_t out_res;

	scrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.id_byte   (id_byte)
	);

	scrc_frame #(
		.REPORT_BYTES (REPORT_BYTES)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.id_byte   (id_byte),
		.out_room  (out_room),
		.res_push  (res_push),
		.res       (res)
	);

	scrc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res       (res),
		.out_room  (out_room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.received_crc, out_res.computed_crc, out_res.verdict};
	assign m_tuser = out_res.header_present;

endmodule

FILE: src/scrc_cfg.sv
// APB register bank holding the expected report identifier.
module scrc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [scrc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [7:0]                         id_byte
);

	logic [7:0] id_byte_q;
	logic       sel_id;

	assign pready = 1'b1;
	assign sel_id = (paddr == scrc_pkg::REG_REPORT_ID_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_byte_q <= scrc_pkg::REPORT_ID_RESET;
		end else if (psel && penable && pwrite && pready && sel_id) begin
			id_byte_q <= pwdata[7:0];
		end
	end

	assign prdata  = sel_id ? {24'd0, id_byte_q} : 32'd0;
	assign id_byte = id_byte_q;

endmodule

FILE: src/scrc_frame.sv
// Input register, per-report state and verdict logic of the report checker.
`include "seeded_crc32_report_checker_top_macros.svh"

module scrc_frame #(
	parameter int unsigned REPORT_BYTES = scrc_pkg::REPORT_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic [7:0]            id_byte,
	input  logic                  out_room,
	output logic                  res_push,
	output scrc_pkg::result_t     res
);

	localparam int unsigned CntW = $clog2(REPORT_BYTES + 2);
	localparam logic [CntW-1:0] BODY_LIMIT = CntW'(REPORT_BYTES - 4);
	localparam logic [CntW-1:0] CNT_FULL   = CntW'(REPORT_BYTES);
	localparam logic [CntW-1:0] CNT_SAT    = CntW'(REPORT_BYTES + 1);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;

	logic [31:0]     crc_q;
	logic [CntW-1:0] count_q;
	logic            header_q;
	logic            id_ok_q;
	logic [31:0]     cap_q;
	logic            started_q;

	logic [31:0]     crc_n;
	logic [CntW-1:0] count_n;
	logic            header_n;
	logic            id_ok_n;
	logic [31:0]     cap_n;
	logic            is_header;
	logic            go;
	logic [31:0]     computed;

	// The staged byte moves on unless it closes a report and the result slot is held.
	assign go       = valid_s1 && (!last_s1 || out_room);
	assign in_ready = !valid_s1 || go;
	assign res_push = go && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		is_header = !started_q && (byte_s1 == scrc_pkg::HEADER_BYTE);
		crc_n     = crc_q;
		count_n   = count_q;
		header_n  = header_q;
		id_ok_n   = id_ok_q;
		cap_n     = cap_q;
		if (is_header) begin
			header_n = 1'b1;
		end else begin
			if (count_q == '0) begin
				id_ok_n = (byte_s1 == id_byte);
			end
			if (count_q < BODY_LIMIT) begin
				crc_n = scrc_pkg::crc_byte(crc_q, byte_s1);
			end
			cap_n = {byte_s1, cap_q[31:8]};
			if (count_q < CNT_SAT) begin
				count_n = count_q + CntW'(1);
			end
		end
	end

	assign computed = ~crc_n;

	always_comb begin
		res.computed_crc   = computed;
		res.received_crc   = cap_n;
		res.header_present = header_n;
		if ((count_n != CNT_FULL) || !id_ok_n) begin
			res.verdict = scrc_pkg::VERDICT_LEN_ID;
		end else if (computed != cap_n) begin
			res.verdict = scrc_pkg::VERDICT_CRC_FAIL;
		end else begin
			res.verdict = scrc_pkg::VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= scrc_pkg::CRC_SEEDED;
			count_q   <= '0;
			header_q  <= 1'b0;
			id_ok_q   <= 1'b0;
			cap_q     <= '0;
			started_q <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				crc_q     <= scrc_pkg::CRC_SEEDED;
				count_q   <= '0;
				header_q  <= 1'b0;
				id_ok_q   <= 1'b0;
				cap_q     <= '0;
				started_q <= 1'b0;
			end else begin
				crc_q     <= crc_n;
				count_q   <= count_n;
				header_q  <= header_n;
				id_ok_q   <= id_ok_n;
				cap_q     <= cap_n;
				started_q <= 1'b1;
			end
		end
	end

	`SCRC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, res_push,
		!started_q && (count_q == '0) && (crc_q == scrc_pkg::CRC_SEEDED),
		"report state not cleared after the closing byte")
	`SCRC_ASSERT_IMP(a_count_bounded, clk, arst_n, 1'b1, count_q <= CNT_SAT,
		"body count beyond its saturation value")
	`SCRC_ASSERT_IMP(a_header_needs_start, clk, arst_n, header_q || (count_q != '0),
		started_q, "header or body state present outside a report")

endmodule

FILE: src/scrc_out.sv
// Output register holding one verdict until the receiver takes it.
module scrc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  scrc_pkg::result_t res,
	output logic              out_room,
	output logic              out_valid,
	input  logic              out_ready,
	output scrc_pkg::result_t out_res
);

	logic              valid_q;
	scrc_pkg::result_t res_q;

	assign out_room = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
